// ----- design/fp_mantissa_align_normalize_unit_assert.svh -----
`ifndef FP_MANTISSA_ALIGN_NORMALIZE_UNIT_ASSERT_SVH
`define FP_MANTISSA_ALIGN_NORMALIZE_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define FPMAN_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define FPMAN_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/fpman_pkg.sv -----
package fpman_pkg;

    localparam int WORD_W    = 32;
    localparam int MANT_W    = 4 * WORD_W;
    localparam int IDX_W     = $clog2(WORD_W);
    localparam int MANT_BITS = 115;
    localparam int LEAD_BIT  = 18;
    localparam int EXP_BITS  = 16;
    localparam int EXP_IO_W  = 16;
    localparam int EXP_EFF   = (EXP_BITS < EXP_IO_W) ? EXP_BITS : EXP_IO_W;
    // room for the word moves and the fine adjust before saturation
    localparam int EXP_W     = EXP_IO_W + 2;

    localparam logic signed [EXP_W-1:0] EXP_MAX = EXP_W'((1 << (EXP_EFF - 1)) - 1);
    localparam logic signed [EXP_W-1:0] EXP_MIN = -EXP_W'(1 << (EXP_EFF - 1));

    localparam logic CMD_SHIFT = 1'b0;
    localparam logic CMD_NORM  = 1'b1;

    typedef struct packed {
        logic             right;
        logic [IDX_W-1:0] amt;
    } t_fine_ctl;

endpackage

// ----- design/fp_mantissa_align_normalize_unit.sv -----
// throughput: one item per cycle while the output is not held; when it is held, a
// stage holds only if it and every stage after it are valid, so bubbles are filled
// stage 1 moves whole words, stage 2 finds the leading one and the partial sticky,
// stage 3 does the sub-word shift and exponent saturation
// reset (synchronous, active low) clears the three stage valid bits; data is not reset
module fp_mantissa_align_normalize_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_cmd,
    input  logic [fpman_pkg::WORD_W-1:0]       i_mant_word0,
    input  logic [fpman_pkg::WORD_W-1:0]       i_mant_word1,
    input  logic [fpman_pkg::WORD_W-1:0]       i_mant_word2,
    input  logic [fpman_pkg::WORD_W-1:0]       i_mant_word3,
    input  logic signed [fpman_pkg::EXP_IO_W-1:0] i_exponent_in,
    input  logic                               i_sticky_in,
    input  logic [7:0]                         i_shift_amount,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [fpman_pkg::WORD_W-1:0]       o_mant_out0,
    output logic [fpman_pkg::WORD_W-1:0]       o_mant_out1,
    output logic [fpman_pkg::WORD_W-1:0]       o_mant_out2,
    output logic [fpman_pkg::WORD_W-1:0]       o_mant_out3,
    output logic signed [fpman_pkg::EXP_IO_W-1:0] o_exponent_out,
    output logic                               o_sticky_out,
    output logic                               o_is_zero
);
    import fpman_pkg::*;

    `include "fp_mantissa_align_normalize_unit_assert.svh"

    typedef struct packed {
        logic              cmd;
        logic [MANT_W-1:0] mant;
        logic [EXP_W-1:0]  exp;
        logic              sticky;
        logic [IDX_W-1:0]  part;
        logic              zero;
    } t_s1;

    typedef struct packed {
        logic              cmd;
        logic [MANT_W-1:0] mant;
        logic [EXP_W-1:0]  exp;
        logic              sticky;
        logic              zero;
        t_fine_ctl         ctl;
    } t_s2;

    typedef struct packed {
        logic                cmd;
        logic [MANT_W-1:0]   mant;
        logic [EXP_IO_W-1:0] exp;
        logic                sticky;
        logic                zero;
    } t_s3;

    function automatic logic [IDX_W-1:0] lead_pos(input logic [WORD_W-1:0] v);
        logic [IDX_W-1:0] p;
        p = '0;
        for (int i = 1; i < WORD_W; i++) begin
            if (v[i]) begin
                p = IDX_W'(i);
            end
        end
        return p;
    endfunction

    logic r_v1, r_v2, r_v3;
    t_s1  r_s1, n_s1;
    t_s2  r_s2, n_s2;
    t_s3  r_s3, n_s3;

    logic rdy1, rdy2, rdy3;

    logic [MANT_W-1:0] w_in;
    logic [IDX_W-1:0]  msb;
    logic              lost_part;
    logic [MANT_W-1:0] fine_mant;
    logic signed [EXP_W-1:0] exp2;

    assign rdy3    = !r_v3 || !i_stall;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_stall = !rdy1;

    // stage 1: whole-word moves
    always_comb begin
        w_in        = {i_mant_word0, i_mant_word1, i_mant_word2, i_mant_word3};
        n_s1.cmd    = i_cmd;
        n_s1.mant   = w_in;
        n_s1.exp    = EXP_W'(i_exponent_in);
        n_s1.sticky = i_sticky_in;
        n_s1.part   = '0;
        n_s1.zero   = 1'b0;
        if (i_cmd == CMD_SHIFT) begin
            if ({1'b0, i_shift_amount} >= 9'(MANT_BITS)) begin
                n_s1.mant   = '0;
                n_s1.sticky = 1'b1;
            end else begin
                n_s1.part = i_shift_amount[IDX_W-1:0];
                case (i_shift_amount[6:5])
                    2'd1: begin
                        n_s1.mant   = w_in >> WORD_W;
                        n_s1.sticky = i_sticky_in | (|w_in[WORD_W-1:0]);
                    end
                    2'd2: begin
                        n_s1.mant   = w_in >> (2 * WORD_W);
                        n_s1.sticky = i_sticky_in | (|w_in[2*WORD_W-1:0]);
                    end
                    2'd3: begin
                        n_s1.mant   = w_in >> (3 * WORD_W);
                        n_s1.sticky = i_sticky_in | (|w_in[3*WORD_W-1:0]);
                    end
                    default: begin
                        n_s1.mant = w_in;
                    end
                endcase
            end
        end else begin
            if (w_in[4*WORD_W-1:3*WORD_W] != '0) begin
                n_s1.mant = w_in;
            end else if (w_in[3*WORD_W-1:2*WORD_W] != '0) begin
                n_s1.mant = w_in << WORD_W;
                n_s1.exp  = EXP_W'(i_exponent_in) - EXP_W'(WORD_W);
            end else if (w_in[2*WORD_W-1:WORD_W] != '0) begin
                n_s1.mant = w_in << (2 * WORD_W);
                n_s1.exp  = EXP_W'(i_exponent_in) - EXP_W'(2 * WORD_W);
            end else if (w_in[WORD_W-1:0] != '0) begin
                n_s1.mant = w_in << (3 * WORD_W);
                n_s1.exp  = EXP_W'(i_exponent_in) - EXP_W'(3 * WORD_W);
            end else begin
                n_s1.zero = 1'b1;
            end
        end
    end

    // stage 2: leading one of the top word, sticky of the partial shift
    always_comb begin
        msb         = lead_pos(r_s1.mant[MANT_W-1:MANT_W-WORD_W]);
        lost_part   = |(r_s1.mant[WORD_W-1:0] << ((IDX_W+1)'(WORD_W) - {1'b0, r_s1.part}));
        n_s2.cmd    = r_s1.cmd;
        n_s2.mant   = r_s1.mant;
        n_s2.exp    = r_s1.exp;
        n_s2.sticky = r_s1.sticky;
        n_s2.zero   = r_s1.zero;
        n_s2.ctl    = '{right: 1'b1, amt: '0};
        if (r_s1.cmd == CMD_SHIFT) begin
            n_s2.sticky  = r_s1.sticky | lost_part;
            n_s2.ctl.amt = r_s1.part;
        end else if (!r_s1.zero) begin
            n_s2.exp = r_s1.exp + EXP_W'(msb) - EXP_W'(LEAD_BIT);
            if (msb > IDX_W'(LEAD_BIT)) begin
                // supernormal: the low word does not feed the result or sticky
                n_s2.mant[WORD_W-1:0] = '0;
                n_s2.ctl.amt          = msb - IDX_W'(LEAD_BIT);
            end else begin
                n_s2.ctl.right = 1'b0;
                n_s2.ctl.amt   = IDX_W'(LEAD_BIT) - msb;
            end
        end
    end

    // stage 3: fine shift and exponent saturation
    fpman_fine_shift u_fine_shift (
        .i_mant (r_s2.mant),
        .i_ctl  (r_s2.ctl),
        .o_mant (fine_mant)
    );

    always_comb begin
        exp2        = $signed(r_s2.exp);
        n_s3.cmd    = r_s2.cmd;
        n_s3.mant   = fine_mant;
        n_s3.sticky = r_s2.sticky;
        n_s3.zero   = r_s2.zero;
        if (exp2 > EXP_MAX) begin
            n_s3.exp = EXP_MAX[EXP_IO_W-1:0];
        end else if (exp2 < EXP_MIN) begin
            n_s3.exp = EXP_MIN[EXP_IO_W-1:0];
        end else begin
            n_s3.exp = r_s2.exp[EXP_IO_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1 <= n_s1;
        end
        if (rdy2) begin
            r_s2 <= n_s2;
        end
        if (rdy3) begin
            r_s3 <= n_s3;
        end
    end

    assign o_valid        = r_v3;
    assign o_mant_out0    = r_s3.mant[4*WORD_W-1:3*WORD_W];
    assign o_mant_out1    = r_s3.mant[3*WORD_W-1:2*WORD_W];
    assign o_mant_out2    = r_s3.mant[2*WORD_W-1:WORD_W];
    assign o_mant_out3    = r_s3.mant[WORD_W-1:0];
    assign o_exponent_out = $signed(r_s3.exp);
    assign o_sticky_out   = r_s3.sticky;
    assign o_is_zero      = r_s3.zero;

    `FPMAN_CHECK(a_norm_lead, o_valid && r_s3.cmd == CMD_NORM && !r_s3.zero, o_mant_out0[LEAD_BIT] && (o_mant_out0 >> (LEAD_BIT + 1)) == '0, "normalized result lacks leading one at lead bit")
    `FPMAN_CHECK(a_shift_no_zero, o_valid && r_s3.cmd == CMD_SHIFT, !o_is_zero, "shift result flagged as zero")
    `FPMAN_CHECK(a_stall_full, o_stall, r_v1 && r_v2 && r_v3, "input stalled with a free stage")
    `FPMAN_CHECK_NEXT(a_drain, o_valid && !i_stall && !r_v2, !o_valid, "output valid without an item behind it")

endmodule

// ----- design/fpman_fine_shift.sv -----
module fpman_fine_shift (
    input  logic [fpman_pkg::MANT_W-1:0] i_mant,
    input  fpman_pkg::t_fine_ctl         i_ctl,
    output logic [fpman_pkg::MANT_W-1:0] o_mant
);
    import fpman_pkg::*;

    // sub-word barrel shift in either direction, zero fill
    always_comb begin
        if (i_ctl.right) begin
            o_mant = i_mant >> i_ctl.amt;
        end else begin
            o_mant = i_mant << i_ctl.amt;
        end
    end

endmodule
